FILE: src/assert_macros.svh
// assertion macros for the route table project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, pre, post)
`define ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

FILE: src/mort_pkg.sv
// ---------------------------------------------------------------------------
// mort_pkg
// types and constants shared by the originator route table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mort_pkg;
    localparam int TableEntriesDefault = 16;
    localparam int NodeIdBitsDefault   = 32;
    localparam logic [19:0] TimeoutReset = 20'd15000;
    localparam logic [7:0]  OwnTq  = 8'd255;
    localparam logic [7:0]  OwnTtl = 8'd50;

    localparam logic [2:0] MODE_RECV   = 3'd0;
    localparam logic [2:0] MODE_STATIC = 3'd1;
    localparam logic [2:0] MODE_LOOKUP = 3'd2;
    localparam logic [2:0] MODE_PRUNE  = 3'd3;
    localparam logic [2:0] MODE_OWN    = 3'd4;

    localparam logic CFG_NODE_ID = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic decide;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } stat_t;
endpackage
`default_nettype wire

FILE: src/mort_ctrl.sv
// ---------------------------------------------------------------------------
// mort_ctrl
// sequencer: load beat, scan table entries, decide, present result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mort_ctrl
    import mort_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd,
    input  stat_t     stat
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_PREP;
            end
            ST_PREP:   state_next = ST_SCAN;
            ST_SCAN: begin
                if (stat.scan_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load     = s_tvalid;
                cmd.scan_clr = 1'b1;
            end
            ST_PREP:   ;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_OUT:    m_tvalid = 1'b1;
            default:   ;
        endcase
    end

    `ASSERT_IMPLIES(a_out_no_take, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_load_prep, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_PREP)
    `ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
endmodule
`default_nettype wire

FILE: src/mort_dpath.sv
// ---------------------------------------------------------------------------
// mort_dpath
// route entries, one-entry-per-cycle scan, update and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mort_dpath
    import mort_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int NODE_ID_BITS  = NodeIdBitsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic [253:0] in_beat,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic [150:0]     out_beat
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = (NODE_ID_BITS < 32) ? NODE_ID_BITS : 32;

    logic [31:0] node_id_reg;
    logic [19:0] timeout_reg;
    logic [31:0] own_seq_reg;
    logic [253:0] beat_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [KW-1:0] dest_mem [TABLE_ENTRIES];
    logic [31:0]   hop_mem  [TABLE_ENTRIES];
    logic [31:0]   seq_mem  [TABLE_ENTRIES];
    logic [7:0]    q_mem    [TABLE_ENTRIES];
    logic [47:0]   stamp_mem[TABLE_ENTRIES];

    logic [CW-1:0] idx_reg;
    logic          hit_reg, free_found_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [CW-1:0] pruned_reg;
    logic [7:0]    tq_reg;
    logic [15:0]   prod_reg;
    logic [150:0]  out_reg;
    logic [150:0]  out_next;

    logic [2:0]  mode;
    logic [31:0] orig, sender, seq, target, hop;
    logic [7:0]  ltq, ttl, metric;
    logic signed [8:0] rssi;
    logic signed [9:0] snr;
    logic [47:0] now;
    assign mode   = beat_reg[2:0];
    assign orig   = beat_reg[34:3];
    assign sender = beat_reg[66:35];
    assign seq    = beat_reg[98:67];
    assign ltq    = beat_reg[106:99];
    assign ttl    = beat_reg[114:107];
    assign rssi   = beat_reg[123:115];
    assign snr    = beat_reg[133:124];
    assign now    = beat_reg[181:134];
    assign target = beat_reg[213:182];
    assign hop    = beat_reg[245:214];
    assign metric = beat_reg[253:246];

    logic [IW-1:0] idx;
    logic [KW-1:0] key;
    logic          match, expired;
    assign idx  = idx_reg[IW-1:0];
    assign key  = (mode == MODE_RECV) ? orig[KW-1:0] : target[KW-1:0];
    assign match = valid_reg[idx] && dest_mem[idx] == key;
    assign expired = valid_reg[idx] && ((now - stamp_mem[idx]) > {28'd0, timeout_reg});
    assign stat.scan_last = (idx_reg == CW'(TABLE_ENTRIES - 1));

    // penalty select and scaling, divide by 255 as multiply by 0x8081 >> 23
    logic signed [11:0] margin;
    logic [7:0]  pen;
    logic [15:0] prod;
    logic [31:0] recip;
    logic [7:0]  tq_calc;
    always_comb begin
        margin = 12'(4 * 12'(rssi)) + 12'(snr) + 12'sd400;
        if (margin < 12'sd40)      pen = 8'd180;
        else if (margin < 12'sd80) pen = 8'd210;
        else                       pen = 8'd250;
        prod = ltq * pen;
        recip = 32'(prod_reg) * 32'd32897;
        tq_calc = recip[30:23];
        if (tq_calc == 8'd0) tq_calc = 8'd1;
    end

    // decision
    logic drop, take, full, wr_en, hit_live;
    logic [IW-1:0] wr_idx;
    logic [31:0]   d;
    logic [10:0]   lhs, rhs;
    assign hit_live = hit_reg && (mode != MODE_PRUNE);
    always_comb begin
        drop = (orig[KW-1:0] == node_id_reg[KW-1:0]) || (ttl <= 8'd1);
        d    = seq - seq_mem[hit_idx_reg];
        lhs  = 11'(tq_reg) * 11'd5;
        rhs  = 11'(q_mem[hit_idx_reg]) * 11'd6;
        take = 1'b0;
        full = 1'b0;
        wr_en = 1'b0;
        wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
        case (mode)
            MODE_RECV: if (!drop) begin
                if (!hit_reg) begin
                    full = !free_found_reg;
                    take = free_found_reg;
                end else begin
                    take = (d != 32'd0 && !d[31]) || (d == 32'd0 && lhs > rhs);
                end
                wr_en = take;
            end
            MODE_STATIC: begin
                if (!hit_reg) begin
                    full = !free_found_reg;
                    take = free_found_reg;
                end else begin
                    take = q_mem[hit_idx_reg] < metric;
                end
                wr_en = take;
            end
            default: ;
        endcase
    end

    // result beat
    always_comb begin
        out_next = '0;
        case (mode)
            MODE_RECV: begin
                out_next[0]   = take;
                out_next[145] = full;
                if (take) begin
                    out_next[64:33]   = orig;
                    out_next[96:65]   = node_id_reg;
                    out_next[128:97]  = seq;
                    out_next[136:129] = tq_reg;
                    out_next[144:137] = ttl - 8'd1;
                end
            end
            MODE_STATIC: begin
                out_next[0]   = take;
                out_next[145] = full;
            end
            MODE_LOOKUP: begin
                out_next[0] = hit_reg;
                if (hit_reg) out_next[32:1] = hop_mem[hit_idx_reg];
            end
            MODE_PRUNE: out_next[150:146] = 5'(pruned_reg);
            MODE_OWN: begin
                out_next[64:33]   = node_id_reg;
                out_next[96:65]   = node_id_reg;
                out_next[128:97]  = own_seq_reg;
                out_next[136:129] = OwnTq;
                out_next[144:137] = OwnTtl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= '0;
            timeout_reg <= TimeoutReset;
            own_seq_reg <= '0;
            valid_reg   <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NODE_ID) node_id_reg <= cfg_wdata;
                else                          timeout_reg <= cfg_wdata[19:0];
            end
            if (cmd.scan_step && mode == MODE_PRUNE && expired) valid_reg[idx] <= 1'b0;
            if (cmd.decide && wr_en) valid_reg[wr_idx] <= 1'b1;
            if (cmd.decide && mode == MODE_OWN) own_seq_reg <= own_seq_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (cmd.load) beat_reg <= in_beat;
        if (cmd.scan_clr) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            pruned_reg <= '0;
        end
        if (cmd.scan_step) begin
            tq_reg <= tq_calc;
            idx_reg <= idx_reg + CW'(1);
            if (match && !hit_reg) begin
                hit_reg <= 1'b1;
                hit_idx_reg <= idx;
            end
            if (!valid_reg[idx] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg <= idx;
            end
            if (mode == MODE_PRUNE && expired) pruned_reg <= pruned_reg + CW'(1);
        end
        if (cmd.decide) begin
            if (wr_en) begin
                dest_mem[wr_idx] <= key;
                if (mode == MODE_RECV) begin
                    hop_mem[wr_idx]   <= 32'(sender[KW-1:0]);
                    seq_mem[wr_idx]   <= seq;
                    q_mem[wr_idx]     <= tq_reg;
                    stamp_mem[wr_idx] <= now;
                end else begin
                    hop_mem[wr_idx]   <= 32'(hop[KW-1:0]);
                    seq_mem[wr_idx]   <= '0;
                    q_mem[wr_idx]     <= metric;
                    stamp_mem[wr_idx] <= '0;
                end
            end
            out_reg <= out_next;
        end
    end
    assign out_beat = out_reg;

    `ASSERT_IMPLIES(a_wr_free, aclk, aresetn, cmd.decide && wr_en && !hit_reg, !valid_reg[wr_idx])
    `ASSERT_IMPLIES(a_hit_valid, aclk, aresetn, cmd.decide && hit_live, valid_reg[hit_idx_reg])
    `ASSERT_IMPLIES(a_full_excl, aclk, aresetn, cmd.decide, !(full && take))
endmodule
`default_nettype wire

FILE: src/mesh_originator_route_table.sv
// ---------------------------------------------------------------------------
// mesh_originator_route_table
// originator route table: receive, static write, lookup, prune, own message
// ---------------------------------------------------------------------------
// one beat in on s_*, exactly one result beat out on m_* per input beat.
// an input beat is loaded, then the table is scanned one entry per cycle
// by a single compare/expiry unit, then the update and result are formed.
// after accept the controller steps through PREP, SCAN, DECIDE and OUT.
// s_tready is high only while no beat is in flight; the result is held in
// an output register until m_tready, and the block waits while stalled.
// reset clears all entry valid bits, own sequence and node id (0) and sets
// the timeout (15000 ms); entries read only when valid. cfg_we writes
// register cfg_index (0 node id, 1 timeout); the user must write it only
// while idle, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mesh_originator_route_table
    import mort_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int NODE_ID_BITS  = NodeIdBitsDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode, originator, sender, seq, link tq, ttl, rssi, snr, now,
    // target, target hop, metric
    input  wire logic [255:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted, lookup hop, msg originator, msg sender, msg seq, msg tq,
    // msg ttl, table full, pruned count
    output logic [151:0]      m_tdata
);
    cmd_t  cmd;
    stat_t stat;
    logic [150:0] out_beat;

    mort_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .cmd, .stat
    );

    mort_dpath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NODE_ID_BITS(NODE_ID_BITS)
    ) u_dpath (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .in_beat(s_tdata[253:0]),
        .cmd, .stat, .out_beat
    );

    assign m_tdata = {1'b0, out_beat};
endmodule
`default_nettype wire

FILE: test/mesh_originator_route_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mesh_originator_route_table_tb
// self-checking bench for the originator route table
// ---------------------------------------------------------------------------
// a table of directed beats exercises drops, link penalty bands, sequence
// wrap, static writes, lookups, prune and own messages. A random stream over
// a small pool of originators follows; it fills and prunes the table under
// four register settings and four idle/stall mixes. Every result beat is
// compared field by field against a fixed expectation or an in-bench model.
// ---------------------------------------------------------------------------
module mesh_originator_route_table_tb
    import mort_pkg::*;
;

    localparam int Entries = 16;

    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  metric;
        logic [31:0] hop;
        logic [31:0] target;
        logic [47:0] now;
        logic [9:0]  snr;
        logic [8:0]  rssi;
        logic [7:0]  ttl;
        logic [7:0]  ltq;
        logic [31:0] seq;
        logic [31:0] sender;
        logic [31:0] orig;
        logic [2:0]  mode;
    } route_op_t;

    typedef struct packed {
        logic        pad;
        logic [4:0]  pruned;
        logic        full;
        logic [7:0]  ttl;
        logic [7:0]  tq;
        logic [31:0] seq;
        logic [31:0] sender;
        logic [31:0] orig;
        logic [31:0] lookup_hop;
        logic        accepted;
    } route_res_t;

    typedef struct {
        route_op_t  op;
        bit         typed;
        route_res_t res;
    } op_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;

    mesh_originator_route_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // table model
    logic [31:0] node_id;
    logic [19:0] timeout_ms;
    bit          tbl_valid [Entries];
    logic [31:0] tbl_dest  [Entries];
    logic [31:0] tbl_hop   [Entries];
    logic [31:0] tbl_seq   [Entries];
    logic [7:0]  tbl_q     [Entries];
    logic [47:0] tbl_stamp [Entries];
    logic [31:0] own_seq;

    route_res_t  pending_res[$];
    int          errors = 0;
    int          stall_pct = 0;
    int          idle_pct = 0;
    logic [31:0] id_pool [24];
    logic [47:0] now_base = '0;

    function automatic int find_dest(logic [31:0] d);
        for (int i = 0; i < Entries; i++)
            if (tbl_valid[i] && tbl_dest[i] == d) return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < Entries; i++)
            if (!tbl_valid[i]) return i;
        return -1;
    endfunction

    function automatic route_res_t route_update(route_op_t op);
        route_res_t r;
        int         idx;
        int         margin;
        int         pen;
        int         tq;
        bit         take;
        logic [31:0] d;
        r = '0;
        take = 0;
        case (op.mode)
            MODE_RECV: begin
                if (op.orig == node_id || op.ttl <= 1) return r;
                margin = 4 * int'($signed(op.rssi)) + int'($signed(op.snr)) + 400;
                pen = (margin < 40) ? 180 : (margin < 80) ? 210 : 250;
                tq = (int'(op.ltq) * pen) / 255;
                if (tq < 1) tq = 1;
                idx = find_dest(op.orig);
                if (idx < 0) begin
                    idx = find_free();
                    if (idx < 0) begin
                        r.full = 1'b1;
                        return r;
                    end
                    take = 1;
                end else begin
                    d = op.seq - tbl_seq[idx];
                    if (d != 0 && !d[31]) take = 1;
                    else if (d == 0 && 5 * tq > 6 * int'(tbl_q[idx])) take = 1;
                end
                if (take) begin
                    tbl_valid[idx] = 1;
                    tbl_dest[idx]  = op.orig;
                    tbl_hop[idx]   = op.sender;
                    tbl_seq[idx]   = op.seq;
                    tbl_q[idx]     = tq[7:0];
                    tbl_stamp[idx] = op.now;
                    r.accepted = 1'b1;
                    r.orig     = op.orig;
                    r.sender   = node_id;
                    r.seq      = op.seq;
                    r.tq       = tq[7:0];
                    r.ttl      = op.ttl - 8'd1;
                end
            end
            MODE_STATIC: begin
                idx = find_dest(op.target);
                if (idx < 0) begin
                    idx = find_free();
                    if (idx < 0) begin
                        r.full = 1'b1;
                        return r;
                    end
                end else if (!(tbl_q[idx] < op.metric)) begin
                    return r;
                end
                tbl_valid[idx] = 1;
                tbl_dest[idx]  = op.target;
                tbl_hop[idx]   = op.hop;
                tbl_seq[idx]   = '0;
                tbl_q[idx]     = op.metric;
                tbl_stamp[idx] = '0;
                r.accepted = 1'b1;
            end
            MODE_LOOKUP: begin
                idx = find_dest(op.target);
                if (idx >= 0) begin
                    r.accepted   = 1'b1;
                    r.lookup_hop = tbl_hop[idx];
                end
            end
            MODE_PRUNE: begin
                for (int i = 0; i < Entries; i++)
                    if (tbl_valid[i] && (op.now - tbl_stamp[i]) > {28'd0, timeout_ms}) begin
                        tbl_valid[i] = 0;
                        r.pruned = r.pruned + 5'd1;
                    end
            end
            MODE_OWN: begin
                r.orig   = node_id;
                r.sender = node_id;
                r.seq    = own_seq;
                r.tq     = OwnTq;
                r.ttl    = OwnTtl;
                own_seq  = own_seq + 32'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        route_res_t got;
        route_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_res.size() == 0) begin
                report("unexpected beat", got[63:0], 64'd0);
            end else begin
                want = pending_res.pop_front();
                if (got.accepted !== want.accepted)
                    report("accepted", 64'(got.accepted), 64'(want.accepted));
                if (got.lookup_hop !== want.lookup_hop)
                    report("lookup_hop", 64'(got.lookup_hop), 64'(want.lookup_hop));
                if (got.orig !== want.orig)
                    report("msg_originator", 64'(got.orig), 64'(want.orig));
                if (got.sender !== want.sender)
                    report("msg_sender", 64'(got.sender), 64'(want.sender));
                if (got.seq !== want.seq)
                    report("msg_seq", 64'(got.seq), 64'(want.seq));
                if (got.tq !== want.tq)
                    report("msg_tq", 64'(got.tq), 64'(want.tq));
                if (got.ttl !== want.ttl)
                    report("msg_ttl", 64'(got.ttl), 64'(want.ttl));
                if (got.full !== want.full)
                    report("table_full", 64'(got.full), 64'(want.full));
                if (got.pruned !== want.pruned)
                    report("pruned_count", 64'(got.pruned), 64'(want.pruned));
            end
        end
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_beat(input route_op_t op, input bit typed, input route_res_t res);
        route_res_t p;
        s_tvalid <= 1'b1;
        s_tdata  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = route_update(op);
        pending_res.push_back(typed ? res : p);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_res.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_NODE_ID) node_id = val;
        else timeout_ms = val[19:0];
        @(posedge aclk);
    endtask

    function automatic route_op_t mk(logic [2:0] mode, logic [31:0] orig, logic [31:0] seq,
                                     logic [7:0] ltq, logic [7:0] ttl, int rssi, int snr,
                                     logic [47:0] now, logic [31:0] target, logic [7:0] metric);
        route_op_t op;
        op = '0;
        op.mode = mode;
        op.orig = orig;
        op.sender = 32'hFFFF_FFFF;
        op.seq = seq;
        op.ltq = ltq;
        op.ttl = ttl;
        op.rssi = rssi[8:0];
        op.snr = snr[9:0];
        op.now = now;
        op.target = target;
        op.hop = 32'hFFFF_FFFF;
        op.metric = metric;
        return op;
    endfunction

    function automatic route_op_t random_op();
        route_op_t op;
        int          k;
        int          idx;
        op.pad    = '0;
        op.mode   = MODE_RECV;
        op.orig   = id_pool[$urandom_range(0, 23)];
        op.sender = $urandom;
        op.seq    = $urandom;
        op.ltq    = 8'($urandom);
        op.ttl    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        op.rssi   = 9'($urandom_range(0, 255) - 200);
        op.snr    = 10'($urandom);
        now_base  = now_base + $urandom_range(0, 4000);
        op.now    = ($urandom_range(0, 49) == 0) ? 48'({$urandom, $urandom}) : now_base;
        op.target = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 23)];
        op.hop    = $urandom;
        op.metric = 8'($urandom);
        idx = find_dest(op.orig);
        if (idx >= 0) begin
            k = $urandom_range(0, 9);
            if (k < 4) op.seq = tbl_seq[idx] + $urandom_range(1, 5);
            else if (k < 7) op.seq = tbl_seq[idx];
            else if (k < 8) op.seq = tbl_seq[idx] - 1;
        end
        if ($urandom_range(0, 29) == 0) op.orig = node_id;
        k = $urandom_range(0, 99);
        if (k < 55) op.mode = MODE_RECV;
        else if (k < 65) op.mode = MODE_STATIC;
        else if (k < 80) op.mode = MODE_LOOKUP;
        else if (k < 88) op.mode = MODE_PRUNE;
        else if (k < 96) op.mode = MODE_OWN;
        else op.mode = 3'($urandom_range(5, 7));
        return op;
    endfunction

    initial begin
        op_row_t    rows[$];
        op_row_t    row;
        route_res_t z;
        logic [31:0] node_set [4];
        logic [19:0] tmo_set [4];
        int          idle_set [4];
        int          stall_set [4];

        node_id = '0;
        timeout_ms = TimeoutReset;
        own_seq = '0;
        for (int i = 0; i < Entries; i++) tbl_valid[i] = 0;
        for (int i = 0; i < 24; i++) id_pool[i] = $urandom;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'd1;

        z = '0;
        row.typed = 1; row.res = z;
        row.op = mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'd5, 0); rows.push_back(row);
        row.res = z; row.res.tq = OwnTq; row.res.ttl = OwnTtl;
        row.op = mk(MODE_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.res = z;
        row.op = mk(MODE_RECV, 0, 3, 200, 10, 0, 0, 10, 0, 0); rows.push_back(row);
        row.op = mk(MODE_RECV, 7, 3, 200, 1, 0, 0, 10, 0, 0); rows.push_back(row);
        row.op = mk(MODE_RECV, 7, 3, 200, 0, 0, 0, 10, 0, 0); rows.push_back(row);
        row.res = z; row.res.accepted = 1; row.res.orig = 7; row.res.seq = 32'hFFFF_FFFF;
        row.res.tq = 8'd250; row.res.ttl = 8'd254;
        row.op = mk(MODE_RECV, 7, 32'hFFFF_FFFF, 255, 255, 55, 511, 20, 0, 0);
        rows.push_back(row);
        row.res = z; row.res.accepted = 1; row.res.orig = 8; row.res.tq = 8'd1; row.res.ttl = 8'd1;
        row.op = mk(MODE_RECV, 8, 0, 0, 2, -200, -512, 30, 0, 0); rows.push_back(row);
        row.typed = 0;
        row.op = mk(MODE_RECV, 7, 0, 100, 9, -90, 0, 40, 0, 0); rows.push_back(row);
        row.op = mk(MODE_RECV, 7, 0, 90, 9, -91, 3, 41, 0, 0); rows.push_back(row);
        row.op = mk(MODE_RECV, 7, 0, 255, 9, -80, 0, 42, 0, 0); rows.push_back(row);
        row.op = mk(MODE_RECV, 8, 0, 255, 9, -91, 3, 43, 0, 0); rows.push_back(row);
        row.op = mk(MODE_STATIC, 0, 0, 0, 0, 0, 0, 50, 32'd9, 8'd255); rows.push_back(row);
        row.op = mk(MODE_STATIC, 0, 0, 0, 0, 0, 0, 51, 32'd9, 8'd0); rows.push_back(row);
        row.op = mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 52, 32'd9, 0); rows.push_back(row);
        row.op = mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 53, 32'd7, 0); rows.push_back(row);
        row.op = mk(MODE_PRUNE, 0, 0, 0, 0, 0, 0, 100, 0, 0); rows.push_back(row);
        row.op = mk(MODE_PRUNE, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0); rows.push_back(row);
        row.op = mk(3'd5, 1, 1, 1, 1, 1, 1, 1, 1, 1); rows.push_back(row);
        row.op = mk(3'd6, 1, 1, 1, 1, 1, 1, 1, 1, 1); rows.push_back(row);
        row.op = mk(3'd7, 1, 1, 1, 1, 1, 1, 1, 1, 1); rows.push_back(row);
        row.op = mk(MODE_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.op = mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'd9, 0); rows.push_back(row);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_beat(rows[i].op, rows[i].typed, rows[i].res);
        drain();

        node_set  = '{$urandom, 32'hFFFF_FFFF, $urandom, 32'd0};
        tmo_set   = '{20'd0, 20'hF_FFFF, 20'($urandom), 20'd15000};
        idle_set  = '{0, 50, 0, 30};
        stall_set = '{0, 0, 50, 30};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_NODE_ID, node_set[ph]);
            write_reg(CFG_TIMEOUT, {12'd0, tmo_set[ph]});
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < 170; n++) begin
                if (ph == 1 && n == 80) begin
                    s_tvalid <= 1'b0;
                    wait (pending_res.size() == 0);
                end
                send_beat(random_op(), 0, z);
            end
            drain();
        end

        stall_pct = 0;
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/mort_pkg.sv
src/mort_ctrl.sv
src/mort_dpath.sv
src/mesh_originator_route_table.sv
test/mesh_originator_route_table_tb.sv
